[hdl/sibq_pkg.sv]
// Package for the seed index bucket query block: widths, opcodes, item types
// and the location packing function. No dependencies; every other file imports it.
package sibq_pkg;

    localparam int MAP_BITS    = 12;
    localparam int KEY_DEPTH   = 65536;
    localparam int MAX_BUCKET  = 64;
    localparam int NUM_BUCKETS = 1 << MAP_BITS;

    localparam int HASH_W = 33;
    localparam int POS_W  = 21;
    localparam int ADDR_W = 16;
    localparam int DATA_W = 64;
    localparam int END_W  = 17;
    localparam int KEY_AW = $clog2(KEY_DEPTH);
    localparam int CNT_W  = $clog2(MAX_BUCKET + 1);

    localparam int TARGET_W     = 32;
    localparam int CHROM_LSB    = 32;
    localparam int CHROM_W      = 10;
    localparam int STRAND_BIT   = 42;
    localparam int KEY_ID_LSB   = STRAND_BIT + 1;
    localparam int KEY_ID_W     = DATA_W - KEY_ID_LSB;
    localparam int SEED_ID_W    = HASH_W - MAP_BITS;
    localparam int ID_CMP_W     = (KEY_ID_W > SEED_ID_W) ? KEY_ID_W : SEED_ID_W;
    localparam int CHROM_SHIFT  = 53;
    localparam int TARGET_SHIFT = 23;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        OP_BUCKET_END = 2'd0,
        OP_KEY_WORD   = 2'd1,
        OP_QUERY      = 2'd2,
        OP_UNUSED     = 2'd3
    } sibq_op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_FINISH
    } sibq_back_state_t;

    typedef struct packed {
        sibq_op_t           opcode;
        logic [ADDR_W-1:0]  address;
        logic [DATA_W-1:0]  write_data;
        logic [HASH_W-1:0]  seed_hash;
        logic               seed_strand;
        logic [POS_W-1:0]   seed_position;
    } sibq_cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0]  location;
        logic               hit;
        logic               truncated;
        logic               last;
    } sibq_res_t;

    // One entry of the queue between the front and the back: a key store
    // write or a query with its resolved scan range.
    typedef struct packed {
        logic                  is_query;
        logic [KEY_AW-1:0]     key_addr;
        logic [DATA_W-1:0]     key_data;
        logic [SEED_ID_W-1:0]  seed_id;
        logic                  strand;
        logic [POS_W-1:0]      qpos;
        logic [KEY_AW-1:0]     start;
        logic [CNT_W-1:0]      count;
        logic                  trunc;
    } sibq_job_t;

    function automatic logic [DATA_W-1:0] pack_location(
        input logic [DATA_W-1:0] key,
        input logic              strand,
        input logic [POS_W-1:0]  qpos
    );
        logic                s;
        logic [POS_W:0]      delta;
        logic [TARGET_W:0]   shifted;
        logic [DATA_W-1:0]   loc;
        s = key[STRAND_BIT] ^ strand;
        // The offset is 2^POS_W, so the reverse strand term never goes negative.
        delta = s ? {1'b0, qpos} : ({1'b1, {POS_W{1'b0}}} - {1'b0, qpos});
        shifted = {1'b0, key[TARGET_W-1:0]} + (TARGET_W + 1)'(delta);
        loc = (DATA_W'(key[CHROM_LSB +: CHROM_W]) << CHROM_SHIFT)
            | (DATA_W'(shifted) << TARGET_SHIFT)
            | (DATA_W'(qpos) << 1)
            | DATA_W'(s);
        return loc;
    endfunction

endpackage

[hdl/sibq_fifo.sv]
// Small job queue between the front and the back of the bucket query block.
// Depends on sibq_pkg for the job type and the queue depth.
module sibq_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sibq_pkg::sibq_job_t push_data,
    output logic                full,
    input  logic                pop,
    output sibq_pkg::sibq_job_t pop_data,
    output logic                empty
);
    import sibq_pkg::*;

    sibq_job_t        slot_reg [Q_DEPTH];
    logic [Q_AW-1:0]  wr_ptr_reg;
    logic [Q_AW-1:0]  rd_ptr_reg;
    logic [Q_AW:0]    count_reg;
    logic [Q_AW:0]    count_next;

    assign full     = (count_reg == (Q_AW + 1)'(Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

[hdl/sibq_front.sv]
// Front part: accepts command items, owns the bucket-end store and turns a
// query into a clipped key range. Depends on sibq_pkg.
module sibq_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  sibq_pkg::sibq_cmd_t cmd,
    output logic                job_push,
    output sibq_pkg::sibq_job_t job,
    input  logic                job_full
);
    import sibq_pkg::*;

    logic [END_W-1:0]     bucket_end_mem [NUM_BUCKETS];

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic                 s1_first_reg;
    sibq_cmd_t            s1_cmd_reg;
    logic [END_W-1:0]     lo_end_reg;
    logic [END_W-1:0]     hi_end_reg;

    logic                 accept;
    logic                 fwd;
    logic [MAP_BITS-1:0]  bucket;

    assign bucket    = cmd.seed_hash[MAP_BITS-1:0];
    assign cmd_stall = s1_valid_reg && job_full;
    assign accept    = cmd_valid && !cmd_stall;
    assign job_push  = s1_valid_reg && !job_full;

    // Only queries and in-range key writes go on to the back.
    assign fwd = (cmd.opcode == OP_QUERY)
              || ((cmd.opcode == OP_KEY_WORD) && (32'(cmd.address) < 32'(KEY_DEPTH)));

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept && fwd)
        begin
            s1_valid_next = 1'b1;
        end
        else if (job_push)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (cmd.opcode == OP_BUCKET_END)
            && (32'(cmd.address) < 32'(NUM_BUCKETS)))
        begin
            bucket_end_mem[cmd.address[MAP_BITS-1:0]] <= cmd.write_data[END_W-1:0];
        end
        if (accept)
        begin
            hi_end_reg   <= bucket_end_mem[bucket];
            lo_end_reg   <= bucket_end_mem[bucket - 1'b1];
            s1_first_reg <= (bucket == '0);
            s1_cmd_reg   <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_comb
    begin
        logic [END_W-1:0] start_e;
        logic [END_W-1:0] stop_e;
        logic [END_W-1:0] span;
        logic             trunc;
        start_e = s1_first_reg ? '0 : lo_end_reg;
        stop_e  = hi_end_reg;
        if (32'(start_e) > 32'(KEY_DEPTH))
        begin
            start_e = END_W'(KEY_DEPTH);
        end
        if (32'(stop_e) > 32'(KEY_DEPTH))
        begin
            stop_e = END_W'(KEY_DEPTH);
        end
        if (stop_e < start_e)
        begin
            stop_e = start_e;
        end
        span  = stop_e - start_e;
        trunc = 32'(span) > 32'(MAX_BUCKET);

        job.is_query = (s1_cmd_reg.opcode == OP_QUERY);
        job.key_addr = s1_cmd_reg.address[KEY_AW-1:0];
        job.key_data = s1_cmd_reg.write_data;
        job.seed_id  = s1_cmd_reg.seed_hash[HASH_W-1:MAP_BITS];
        job.strand   = s1_cmd_reg.seed_strand;
        job.qpos     = s1_cmd_reg.seed_position;
        // An empty range may start at the end of the store; its start is never used.
        job.start    = start_e[KEY_AW-1:0];
        job.count    = trunc ? CNT_W'(MAX_BUCKET) : span[CNT_W-1:0];
        job.trunc    = trunc;
    end

endmodule

[hdl/sibq_back.sv]
// Back part: owns the key store, performs key writes and scans query ranges
// one key per cycle unless a stalled result blocks a match, holding back each
// match until it knows whether it is last. Depends on sibq_pkg.
module sibq_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_empty,
    input  sibq_pkg::sibq_job_t job,
    output logic                job_pop,
    output logic                res_valid,
    input  logic                res_stall,
    output sibq_pkg::sibq_res_t res
);
    import sibq_pkg::*;

    logic [DATA_W-1:0]  key_mem [KEY_DEPTH];

    sibq_back_state_t   state_reg;
    sibq_back_state_t   state_next;
    logic [KEY_AW-1:0]  ptr_reg;
    logic [CNT_W-1:0]   left_reg;
    sibq_job_t          cur_reg;
    logic               cmp_valid_reg;
    logic [DATA_W-1:0]  key_rd_reg;
    logic               held_valid_reg;
    sibq_res_t          held_reg;
    logic               res_valid_reg;
    sibq_res_t          res_reg;

    logic               push_ok;
    logic               match;
    logic               blocked;
    logic               load_job;
    logic               key_we;
    logic               issue;
    logic               take_match;
    logic               push;
    sibq_res_t          push_res;
    sibq_res_t          match_res;

    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign push_ok   = !res_valid_reg || !res_stall;

    assign match = cmp_valid_reg
                && (ID_CMP_W'(key_rd_reg >> KEY_ID_LSB) == ID_CMP_W'(cur_reg.seed_id));
    // A second match cannot be taken while the held one has nowhere to go.
    assign blocked = (state_reg == BK_SCAN) && match && held_valid_reg && !push_ok;

    assign match_res.location  = pack_location(key_rd_reg, cur_reg.strand, cur_reg.qpos);
    assign match_res.hit       = 1'b1;
    assign match_res.truncated = cur_reg.trunc;
    assign match_res.last      = 1'b0;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!job_empty && job.is_query)
                begin
                    state_next = BK_SCAN;
                end
            end
            BK_SCAN:
            begin
                if ((left_reg == '0) && !cmp_valid_reg)
                begin
                    state_next = BK_FINISH;
                end
            end
            BK_FINISH:
            begin
                if (push_ok)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        job_pop    = 1'b0;
        load_job   = 1'b0;
        key_we     = 1'b0;
        issue      = 1'b0;
        take_match = 1'b0;
        push       = 1'b0;
        push_res   = held_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop  = 1'b1;
                    load_job = job.is_query;
                    key_we   = !job.is_query;
                end
            end
            BK_SCAN:
            begin
                if (!blocked)
                begin
                    issue = (left_reg != '0);
                    if (match)
                    begin
                        take_match = 1'b1;
                        push       = held_valid_reg;
                    end
                end
            end
            BK_FINISH:
            begin
                if (push_ok)
                begin
                    push = 1'b1;
                    if (held_valid_reg)
                    begin
                        push_res.last = 1'b1;
                    end
                    else
                    begin
                        push_res.location  = '0;
                        push_res.hit       = 1'b0;
                        push_res.truncated = cur_reg.trunc;
                        push_res.last      = 1'b1;
                    end
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[job.key_addr] <= job.key_data;
        end
        if (issue)
        begin
            key_rd_reg <= key_mem[ptr_reg];
        end
        if (load_job)
        begin
            cur_reg <= job;
        end
        if (take_match)
        begin
            held_reg <= match_res;
        end
        if (push)
        begin
            res_reg <= push_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            ptr_reg        <= '0;
            left_reg       <= '0;
            cmp_valid_reg  <= 1'b0;
            held_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_job)
            begin
                ptr_reg  <= job.start;
                left_reg <= job.count;
            end
            else if (issue)
            begin
                ptr_reg  <= ptr_reg + 1'b1;
                left_reg <= left_reg - 1'b1;
            end
            if (!blocked)
            begin
                cmp_valid_reg <= issue;
            end
            if (take_match)
            begin
                held_valid_reg <= 1'b1;
            end
            else if ((state_reg == BK_FINISH) && push_ok)
            begin
                held_valid_reg <= 1'b0;
            end
            if (push)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

endmodule

[hdl/seed_index_bucket_query.sv]
// Seed index bucket query block.
// Command items arrive on cmd (cmd_valid / cmd_stall) and carry an opcode:
// a bucket-end write, a key word write, or a query for one seed. Writes give
// no result; a query gives one result item on res (res_valid / res_stall) for
// every matching key in the first MAX_BUCKET of its bucket, in key order, with
// last set on the final one, or a single no-hit item when nothing matches.
// For a query the front reads the bucket-end store into registers and clips
// the range as the job is queued; the back then scans at most MAX_BUCKET keys,
// reading the key store one slot per cycle while no stalled result blocks it;
// that key store read port sets the rate. A key write is done by the idle back
// and starts no scan. A four-entry queue separates the front from the back,
// so commands keep being taken while a scan runs.
// Reset clears all control state; both stores are left as they are and must
// be written before they are read. A stalled result holds on res; the back
// pauses its scan and the queue fills until cmd_stall rises.
// Depends on sibq_pkg, sibq_front, sibq_fifo and sibq_back.
module seed_index_bucket_query (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  sibq_pkg::sibq_cmd_t cmd,
    output logic                res_valid,
    input  logic                res_stall,
    output sibq_pkg::sibq_res_t res
);
    import sibq_pkg::*;

    logic       job_push;
    logic       job_full;
    logic       job_pop;
    logic       job_empty;
    sibq_job_t  job_in;
    sibq_job_t  job_out;

    sibq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .job_push  (job_push),
        .job       (job_in),
        .job_full  (job_full)
    );

    sibq_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .full      (job_full),
        .pop       (job_pop),
        .pop_data  (job_out),
        .empty     (job_empty)
    );

    sibq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job       (job_out),
        .job_pop   (job_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

`ifndef SYNTHESIS
    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(job_push && job_full))
        else $error("job queue written while full");

    a_queue_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(job_pop && job_empty))
        else $error("job queue read while empty");

    a_nohit_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.hit) |-> (res.last && (res.location == '0)))
        else $error("no-hit item without last or with a location");

    a_res_held_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> (res_valid && $stable(res)))
        else $error("stalled result item changed or dropped");
`endif

endmodule

[sim/seed_index_bucket_query_tb.sv]
// Self-checking testbench for seed_index_bucket_query: loads the bucket-end and key stores,
// runs seed lookups and checks every result item against a predictor of the lookup.
// Depends on sibq_pkg and the seed_index_bucket_query RTL.
module seed_index_bucket_query_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sibq_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 4;
    localparam int RANDOM_ITEMS = 250;
    localparam int POOL_SIZE    = 8;
    localparam int TAIL_CYCLES  = MAX_BUCKET + 16;
    localparam int PRINT_CAP    = 200;
    // Worst case is a full 64-hit scan behind the longest result stall for every
    // item, plus sender gaps; this limit sits several times above that.
    localparam int unsigned CYCLE_LIMIT = 10_000_000;

    localparam sibq_res_t NO_HIT = '{location: '0, hit: 1'b0, truncated: 1'b0, last: 1'b1};

    typedef struct {
        sibq_cmd_t cmd;
        bit        typed;
    } stim_row_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_stall;
    sibq_cmd_t cmd;
    logic      res_valid;
    logic      res_stall;
    sibq_res_t res;

    // Predictor copy of both stores, with a flag per entry that has been written.
    bit [END_W-1:0]  bucket_end_mem [NUM_BUCKETS];
    bit              bucket_end_set [NUM_BUCKETS];
    bit [DATA_W-1:0] key_mem [KEY_DEPTH];
    bit              key_set [KEY_DEPTH];

    sibq_res_t           lookup_results_due [$];
    stim_row_t           directed_rows [$];
    logic [MAP_BITS-1:0] bucket_pool [POOL_SIZE];

    int unsigned mismatch_count = 0;
    int unsigned accepted_items = 0;
    int unsigned cycle_count    = 0;
    bit          burst_mode     = 1'b0;

    seed_index_bucket_query u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    function automatic bit [DATA_W-1:0] expected_location(input bit [DATA_W-1:0] key,
                                                          input bit strand,
                                                          input bit [POS_W-1:0] qpos);
        bit              s;
        bit [DATA_W-1:0] shifted;
        s = key[STRAND_BIT] ^ strand;
        // Forward strand adds the query position, reverse adds 2^21 minus it; carries are kept.
        shifted = DATA_W'(key[TARGET_W-1:0])
                + (s ? DATA_W'(qpos) : (DATA_W'(1) << POS_W) - DATA_W'(qpos));
        return (DATA_W'(key[CHROM_LSB +: CHROM_W]) << CHROM_SHIFT)
             | (shifted << TARGET_SHIFT)
             | (DATA_W'(qpos) << 1)
             | DATA_W'(s);
    endfunction

    function automatic void scan_range(input logic [MAP_BITS-1:0] b, output int unsigned lo,
                                       output int unsigned hi, output bit cut);
        lo = (b == 0) ? 0 : bucket_end_mem[b - 1];
        hi = bucket_end_mem[b];
        if (lo > KEY_DEPTH)
            lo = KEY_DEPTH;
        if (hi > KEY_DEPTH)
            hi = KEY_DEPTH;
        if (hi < lo)
            hi = lo;
        cut = (hi - lo > MAX_BUCKET);
        if (cut)
            hi = lo + MAX_BUCKET;
    endfunction

    function automatic void predict_lookup(input sibq_cmd_t c);
        int unsigned         lo;
        int unsigned         hi;
        int unsigned         p;
        bit                  cut;
        int unsigned         hits [$];
        sibq_res_t           r;
        logic [SEED_ID_W-1:0] id;
        scan_range(c.seed_hash[MAP_BITS-1:0], lo, hi, cut);
        id = c.seed_hash[HASH_W-1:MAP_BITS];
        for (p = lo; p < hi; p++)
            if (key_mem[p][DATA_W-1:KEY_ID_LSB] == id)
                hits.push_back(p);
        if (hits.size() == 0)
        begin
            r = NO_HIT;
            r.truncated = cut;
            lookup_results_due.push_back(r);
        end
        foreach (hits[k])
        begin
            r.location  = expected_location(key_mem[hits[k]], c.seed_strand, c.seed_position);
            r.hit       = 1'b1;
            r.truncated = cut;
            r.last      = (k == hits.size() - 1);
            lookup_results_due.push_back(r);
        end
    endfunction

    // Update the store copies for an accepted item, or queue what a lookup returns.
    function automatic void record_cmd(input sibq_cmd_t c, input bit typed);
        case (c.opcode)
            OP_BUCKET_END:
                if (c.address < NUM_BUCKETS)
                begin
                    bucket_end_mem[c.address[MAP_BITS-1:0]] = c.write_data[END_W-1:0];
                    bucket_end_set[c.address[MAP_BITS-1:0]] = 1'b1;
                    accepted_items++;
                end
            OP_KEY_WORD:
                if (c.address < KEY_DEPTH)
                begin
                    key_mem[c.address] = c.write_data;
                    key_set[c.address] = 1'b1;
                    accepted_items++;
                end
            OP_QUERY:
            begin
                accepted_items++;
                if (typed)
                    lookup_results_due.push_back(NO_HIT);
                else
                    predict_lookup(c);
            end
            default: ;
        endcase
    endfunction

    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic sibq_cmd_t random_fields();
        sibq_cmd_t c;
        c.opcode        = OP_UNUSED;
        c.address       = ADDR_W'($urandom);
        c.write_data    = {$urandom, $urandom};
        c.seed_hash     = HASH_W'({$urandom, $urandom});
        c.seed_strand   = 1'($urandom);
        c.seed_position = POS_W'($urandom);
        return c;
    endfunction

    function automatic bit [DATA_W-1:0] make_key(input logic [SEED_ID_W-1:0] id);
        bit [DATA_W-1:0] k;
        k = {$urandom, $urandom};
        if ($urandom_range(0, 1) == 1)
            k[DATA_W-1:KEY_ID_LSB] = id;
        return k;
    endfunction

    // Entered and left at a falling edge; valid stays high on return so that a
    // back-to-back item never sees valid lowered and raised in one step.
    task automatic issue_cmd(input sibq_cmd_t c, input bit typed);
        int unsigned gap;
        gap = burst_mode ? 0 : idle_gap();
        if (gap != 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (cmd_stall);
        record_cmd(c, typed);
        @(negedge clk);
    endtask

    task automatic write_bucket_end(input int unsigned idx, input bit [DATA_W-1:0] val);
        sibq_cmd_t c;
        c            = random_fields();
        c.opcode     = OP_BUCKET_END;
        c.address    = ADDR_W'(idx);
        c.write_data = val;
        issue_cmd(c, 1'b0);
    endtask

    task automatic write_key(input int unsigned slot, input bit [DATA_W-1:0] val);
        sibq_cmd_t c;
        c            = random_fields();
        c.opcode     = OP_KEY_WORD;
        c.address    = ADDR_W'(slot);
        c.write_data = val;
        issue_cmd(c, 1'b0);
    endtask

    // Before a lookup, write whatever it would read that has never been written.
    task automatic prepare_bucket(input sibq_cmd_t q);
        logic [MAP_BITS-1:0] b;
        int unsigned         lo;
        int unsigned         hi;
        int unsigned         p;
        bit                  cut;
        b = q.seed_hash[MAP_BITS-1:0];
        if (b != 0 && !bucket_end_set[b - 1])
            write_bucket_end(b - 1, $urandom_range(0, 400));
        if (!bucket_end_set[b])
            write_bucket_end(b, ((b == 0) ? 0 : bucket_end_mem[b - 1]) + $urandom_range(0, 8));
        scan_range(b, lo, hi, cut);
        for (p = lo; p < hi; p++)
            if (!key_set[p])
                write_key(p, make_key(q.seed_hash[HASH_W-1:MAP_BITS]));
    endtask

    task automatic wait_results_done();
        cmd_valid <= 1'b0;
        do
            @(negedge clk);
        while (lookup_results_due.size() != 0);
    endtask

    task automatic lookup_sequence();
        logic [MAP_BITS-1:0] b;
        int unsigned         lo;
        int unsigned         hi;
        int unsigned         len;
        int unsigned         r;
        int unsigned         n;
        bit                  cut;
        sibq_cmd_t           q;
        b = ($urandom_range(0, 3) != 0) ? bucket_pool[$urandom_range(0, POOL_SIZE - 1)]
                                        : MAP_BITS'($urandom);
        burst_mode = ($urandom_range(0, 3) == 0);
        // Reshape the bucket now and then: mostly short, sometimes past the scan cap.
        if ($urandom_range(0, 2) == 0)
        begin
            if (b != 0 && !bucket_end_set[b - 1])
                write_bucket_end(b - 1, $urandom_range(0, 400));
            r = $urandom_range(0, 19);
            if (r < 14)
                len = $urandom_range(0, 8);
            else if (r < 18)
                len = $urandom_range(9, MAX_BUCKET);
            else
                len = $urandom_range(MAX_BUCKET + 1, MAX_BUCKET + 20);
            write_bucket_end(b, ((b == 0) ? 0 : bucket_end_mem[b - 1]) + len);
        end
        n = $urandom_range(1, 3);
        repeat (n)
        begin
            q = random_fields();
            q.opcode = OP_QUERY;
            q.seed_hash[MAP_BITS-1:0] = b;
            prepare_bucket(q);
            scan_range(b, lo, hi, cut);
            // Mostly look up a seed id that is present in the bucket.
            if (hi > lo && $urandom_range(0, 9) < 7)
                q.seed_hash[HASH_W-1:MAP_BITS] =
                    key_mem[$urandom_range(lo, hi - 1)][DATA_W-1:KEY_ID_LSB];
            issue_cmd(q, 1'b0);
        end
        burst_mode = 1'b0;
    endtask

    task automatic noise_item();
        int unsigned r;
        sibq_cmd_t   c;
        r = $urandom_range(0, 9);
        c = random_fields();
        if (r < 4)
            write_key(c.address, c.write_data);
        else if (r < 7)
        begin
            c.opcode = OP_BUCKET_END;
            if ($urandom_range(0, 1) == 1)
                c.write_data = $urandom_range(0, 600);
            issue_cmd(c, 1'b0);
        end
        else
            issue_cmd(c, 1'b0);
    endtask

    function automatic void add_row(input sibq_op_t op, input bit [ADDR_W-1:0] addr,
                                    input bit [DATA_W-1:0] data, input bit [HASH_W-1:0] hash,
                                    input bit strand, input bit [POS_W-1:0] qpos,
                                    input bit typed);
        stim_row_t row;
        row.cmd.opcode        = op;
        row.cmd.address       = addr;
        row.cmd.write_data    = data;
        row.cmd.seed_hash     = hash;
        row.cmd.seed_strand   = strand;
        row.cmd.seed_position = qpos;
        row.typed             = typed;
        directed_rows.push_back(row);
    endfunction

    function automatic void build_directed_rows();
        // Bucket zero is empty and starts at key 0.
        add_row(OP_BUCKET_END, 0, 64'hFFFF_FFFF_FFFE_0000, 0, 0, 0, 0);
        add_row(OP_QUERY, 0, 0, {21'd0, 12'd0}, 0, 0, 1);
        // Bucket one holds keys 0 and 1, one per strand, at target and chromosome extremes.
        add_row(OP_BUCKET_END, 1, 2, 0, 0, 0, 0);
        add_row(OP_KEY_WORD, 0, {21'd5, 1'b0, 10'h3FF, 32'hFFFF_FFFF}, 0, 0, 0, 0);
        add_row(OP_KEY_WORD, 1, {21'd6, 1'b1, 10'h000, 32'h0000_0000}, 0, 0, 0, 0);
        add_row(OP_QUERY, 0, 0, {21'd5, 12'd1}, 0, 0, 0);
        add_row(OP_QUERY, 0, 0, {21'd6, 12'd1}, 0, 21'h1F_FFFF, 0);
        add_row(OP_QUERY, 0, 0, {21'd7, 12'd1}, 1, 21'h0A_5A5A, 1);
        // Reversed range: end below start.
        add_row(OP_BUCKET_END, 2, 1, 0, 0, 0, 0);
        add_row(OP_QUERY, 0, 0, {21'd5, 12'd2}, 0, 0, 1);
        // A bucket far longer than the scan cap.
        add_row(OP_BUCKET_END, 3, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0);
        add_row(OP_QUERY, 0, 0, {21'h1F_FFFF, 12'd3}, 1, 21'h10_0000, 0);
        // Ranges past the end of the key store saturate.
        add_row(OP_BUCKET_END, 4, 65530, 0, 0, 0, 0);
        add_row(OP_QUERY, 0, 0, {21'd9, 12'd4}, 0, 0, 1);
        add_row(OP_BUCKET_END, 5, 17'h1_FFFF, 0, 0, 0, 0);
        add_row(OP_QUERY, 0, 0, {21'd9, 12'd5}, 1, 21'd1, 0);
        // Writes to buckets that do not exist, and the unused opcode, are dropped.
        add_row(OP_BUCKET_END, 16'd4096, 0, 0, 0, 0, 0);
        add_row(OP_BUCKET_END, 16'hFFFF, 0, 0, 0, 0, 0);
        add_row(OP_UNUSED, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 33'h1_FFFF_FFFF, 1, 21'h1F_FFFF, 0);
        // Last bucket with the all-ones seed id.
        add_row(OP_BUCKET_END, 4094, 100, 0, 0, 0, 0);
        add_row(OP_BUCKET_END, 4095, 103, 0, 0, 0, 0);
        add_row(OP_QUERY, 0, 0, 33'h1_FFFF_FFFF, 1, 21'h1F_FFFF, 0);
        add_row(OP_KEY_WORD, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0);
        add_row(OP_QUERY, 0, 0, {21'h1F_FFFF, 12'd5}, 0, 21'h1F_FFFF, 0);
    endfunction

    // Result side back-pressure: alternating stall and free spans of random length.
    initial
    begin : res_pacing
        int unsigned span;
        int unsigned r;
        bit          hold;
        res_stall = 1'b0;
        span      = 0;
        hold      = 1'b0;
        forever
        begin
            @(negedge clk);
            if (span == 0)
            begin
                hold = !hold;
                r    = $urandom_range(0, 99);
                if (hold)
                    span = (r < 70) ? $urandom_range(1, 3)
                         : (r < 95) ? $urandom_range(4, 12) : $urandom_range(30, 80);
                else
                    span = (r < 70) ? $urandom_range(1, 6)
                         : (r < 95) ? $urandom_range(7, 40) : $urandom_range(100, 300);
            end
            res_stall <= hold;
            span--;
        end
    end

    always @(posedge clk)
    begin : res_check
        sibq_res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (lookup_results_due.size() == 0)
                report_mismatch($sformatf("result item with none expected: %h", res));
            else
            begin
                want = lookup_results_due.pop_front();
                if (res.location !== want.location)
                    report_mismatch($sformatf("location %h, expected %h",
                                              res.location, want.location));
                if (res.hit !== want.hit)
                    report_mismatch($sformatf("hit %b, expected %b", res.hit, want.hit));
                if (res.truncated !== want.truncated)
                    report_mismatch($sformatf("truncated %b, expected %b",
                                              res.truncated, want.truncated));
                if (res.last !== want.last)
                    report_mismatch($sformatf("last %b, expected %b", res.last, want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        build_directed_rows();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].cmd.opcode == OP_QUERY)
                prepare_bucket(directed_rows[i].cmd);
            issue_cmd(directed_rows[i].cmd, directed_rows[i].typed);
        end
        // Hold off until the directed lookups have all come back.
        wait_results_done();

        bucket_pool[0] = '0;
        bucket_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            bucket_pool[i] = MAP_BITS'($urandom);
        accepted_items = 0;
        while (accepted_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) < 7)
                lookup_sequence();
            else
                noise_item();
            if ($urandom_range(0, 39) == 0)
                wait_results_done();
        end

        wait_results_done();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
